>>> hw/rtl/spdq_pkg.sv
// Shared types and codes for the stable priority dispatch queue.
package spdq_pkg;

   // Request actions.
   typedef enum logic {
      ACT_ENQUEUE = 1'b0,
      ACT_DEQUEUE = 1'b1
   } action_type;

   // Response status codes.
   typedef enum logic [1:0] {
      ST_ENQUEUED = 2'd0,
      ST_DEQUEUED = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // One request as it arrives on the input side.
   typedef struct packed {
      action_type  action;
      logic [15:0] proc_id;
      logic [3:0]  prio_level;
   } req_type;

   // One response as it leaves on the output side.
   typedef struct packed {
      status_type  status;
      logic [15:0] out_id;
      logic [3:0]  out_prio;
      logic [4:0]  fill_level;
   } rsp_type;

   // One stored queue entry.
   typedef struct packed {
      logic [15:0] id;
      logic [3:0]  prio;
   } entry_type;

endpackage

>>> hw/rtl/stable_priority_dispatch_queue.sv
// Stable priority dispatch queue: sorted entry store walked by a small sequencer.
//
// A request is taken when start is high and busy is low; its response appears on
// rsp_data, marked by rsp_strobe for exactly one cycle, and cannot be held off.
// Entries live in a single-port-write, registered-read memory of DEPTH words used
// as a ring with a moving head, so a dequeue never shifts data. A dequeue reads
// the head entry, then registers it into the response. An enqueue walks back
// from the tail, one memory read then one compare per entry it looks at,
// moving each lower-priority entry one slot toward the tail, and then writes
// the new entry. A dequeue of an empty queue or an enqueue into a full one
// answers on the next cycle and leaves busy low. Equal priorities leave in
// arrival order. fill_level reports the entry count modulo 32.
module stable_priority_dispatch_queue #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  spdq_pkg::req_type req_data,
   output logic              rsp_strobe,
   output spdq_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ENQ_RD,
      S_ENQ_CMP,
      S_ENQ_PUT,
      S_DEQ_RD,
      S_DEQ_OUT
   } state_type;

   // Ring address: head plus an offset below DEPTH, folded back once.
   function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] head,
                                               input logic [CW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, head} + (AW+1)'(off);
      if (sum >= (AW+1)'(DEPTH)) begin
         sum = sum - (AW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   state_type           state_ff, state_in;
   logic [AW-1:0]       head_ff, head_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       pos_ff, pos_in;
   spdq_pkg::entry_type new_ff, new_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   spdq_pkg::rsp_type   rsp_ff, rsp_in;

   spdq_pkg::entry_type mem [DEPTH];
   spdq_pkg::entry_type rd_data_ff;
   logic [AW-1:0]       rd_addr;
   logic                rd_en;
   logic [AW-1:0]       wr_addr;
   logic                wr_en;
   spdq_pkg::entry_type wr_data;
   logic                accept;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // Memory port control: one read and one write address per cycle.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = head_ff;
      wr_en   = 1'b0;
      wr_addr = ring_addr(head_ff, pos_ff);
      wr_data = new_ff;
      unique case (state_ff)
         S_ENQ_RD: begin
            rd_en   = 1'b1;
            rd_addr = ring_addr(head_ff, pos_ff - CW'(1));
         end
         S_ENQ_CMP: begin
            if (rd_data_ff.prio < new_ff.prio) begin
               wr_en   = 1'b1;
               wr_data = rd_data_ff;
            end
         end
         S_ENQ_PUT: begin
            wr_en = 1'b1;
         end
         S_DEQ_RD: begin
            rd_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Entry store with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Sequencer next-state and response logic.
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      new_in        = new_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               new_in.id   = req_data.proc_id;
               new_in.prio = req_data.prio_level;
               pos_in      = count_ff;
               if (req_data.action == spdq_pkg::ACT_DEQUEUE) begin
                  if (count_ff == '0) begin
                     rsp_strobe_in      = 1'b1;
                     rsp_in.status      = spdq_pkg::ST_EMPTY;
                     rsp_in.out_id      = '0;
                     rsp_in.out_prio    = '0;
                     rsp_in.fill_level  = 5'(count_ff);
                  end else begin
                     state_in = S_DEQ_RD;
                  end
               end else if (count_ff == CW'(DEPTH)) begin
                  rsp_strobe_in     = 1'b1;
                  rsp_in.status     = spdq_pkg::ST_FULL;
                  rsp_in.out_id     = '0;
                  rsp_in.out_prio   = '0;
                  rsp_in.fill_level = 5'(count_ff);
               end else if (count_ff == '0) begin
                  state_in = S_ENQ_PUT;
               end else begin
                  state_in = S_ENQ_RD;
               end
            end
         end
         S_ENQ_RD: begin
            state_in = S_ENQ_CMP;
         end
         S_ENQ_CMP: begin
            // Lower-priority entry moves one slot toward the tail.
            if (rd_data_ff.prio < new_ff.prio) begin
               pos_in = pos_ff - CW'(1);
               if (pos_ff == CW'(1)) begin
                  state_in = S_ENQ_PUT;
               end else begin
                  state_in = S_ENQ_RD;
               end
            end else begin
               state_in = S_ENQ_PUT;
            end
         end
         S_ENQ_PUT: begin
            count_in          = count_ff + CW'(1);
            rsp_strobe_in     = 1'b1;
            rsp_in.status     = spdq_pkg::ST_ENQUEUED;
            rsp_in.out_id     = '0;
            rsp_in.out_prio   = '0;
            rsp_in.fill_level = 5'(count_ff + CW'(1));
            state_in          = S_IDLE;
         end
         S_DEQ_RD: begin
            state_in = S_DEQ_OUT;
         end
         S_DEQ_OUT: begin
            head_in           = ring_addr(head_ff, CW'(1));
            count_in          = count_ff - CW'(1);
            rsp_strobe_in     = 1'b1;
            rsp_in.status     = spdq_pkg::ST_DEQUEUED;
            rsp_in.out_id     = rd_data_ff.id;
            rsp_in.out_prio   = rd_data_ff.prio;
            rsp_in.fill_level = 5'(count_ff - CW'(1));
            state_in          = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      pos_ff <= pos_in;
      new_ff <= new_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // The entry count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count exceeds capacity");

   // A walk step always has an entry in front of the insertion point.
   a_walk_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ENQ_RD || state_ff == S_ENQ_CMP) |-> pos_ff != '0)
      else $error("enqueue walk past the head");

   // A dequeue response removes exactly one entry.
   a_deq_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_ff.status == spdq_pkg::ST_DEQUEUED)
         |-> count_ff == $past(count_ff) - CW'(1))
      else $error("dequeue did not remove one entry");

   // An empty report only comes from an empty queue.
   a_empty_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_ff.status == spdq_pkg::ST_EMPTY) |-> count_ff == '0)
      else $error("empty reported with entries held");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the stable priority dispatch queue.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH   = 16;
   localparam int RANDOM_ITEMS  = 1425;
   localparam int PHASE_LENGTH  = 48;
   localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 8;
   localparam int REPORT_LIMIT  = 10;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   spdq_pkg::req_type req_data = '0;
   logic              rsp_strobe;
   spdq_pkg::rsp_type rsp_data;

   // Model of the sorted store, head first, and responses still owed.
   spdq_pkg::entry_type held_entries[$];
   spdq_pkg::rsp_type   expected_rsps[$];
   int                  error_count = 0;

   stable_priority_dispatch_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // Apply one request to the modeled store and return the response it earns.
   function automatic spdq_pkg::rsp_type predict_dispatch(spdq_pkg::req_type r);
      spdq_pkg::rsp_type   res;
      spdq_pkg::entry_type e;
      int                  pos;
      res = '0;
      if (r.action == spdq_pkg::ACT_ENQUEUE) begin
         if (held_entries.size() >= QUEUE_DEPTH) begin
            res.status = spdq_pkg::ST_FULL;
         end else begin
            // A new entry goes behind every entry of greater or equal priority.
            pos = 0;
            while (pos < held_entries.size() && held_entries[pos].prio >= r.prio_level)
               pos++;
            e.id   = r.proc_id;
            e.prio = r.prio_level;
            held_entries.insert(pos, e);
            res.status = spdq_pkg::ST_ENQUEUED;
         end
      end else if (held_entries.size() == 0) begin
         res.status = spdq_pkg::ST_EMPTY;
      end else begin
         e = held_entries.pop_front();
         res.status   = spdq_pkg::ST_DEQUEUED;
         res.out_id   = e.id;
         res.out_prio = e.prio;
      end
      res.fill_level = 5'(held_entries.size());
      return res;
   endfunction

   // Build a request with random content; priorities stray out of range now and then.
   function automatic spdq_pkg::req_type make_request(spdq_pkg::action_type act);
      spdq_pkg::req_type r;
      r.action  = act;
      r.proc_id = 16'($urandom);
      if ($urandom_range(0, 99) < 85)
         r.prio_level = 4'($urandom_range(1, 10));
      else
         r.prio_level = 4'($urandom_range(0, 15));
      return r;
   endfunction

   // Present one request after a random gap and hold it until the block takes it.
   task automatic send_request(spdq_pkg::req_type r);
      int gap;
      gap = $urandom_range(0, 3);
      @(negedge clock);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    = 1'b1;
      req_data = r;
      forever begin
         @(posedge clock);
         if (!busy)
            break;
      end
      expected_rsps.push_back(predict_dispatch(r));
   endtask

   // Compare every response with the oldest outstanding prediction.
   always @(posedge clock) begin
      spdq_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("tb: unexpected response %p", rsp_data);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.status !== want.status || rsp_data.out_id !== want.out_id ||
                rsp_data.out_prio !== want.out_prio ||
                rsp_data.fill_level !== want.fill_level) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("tb: mismatch expected %p actual %p", want, rsp_data);
            end
         end
      end
   end

   // A dequeue right after reset must report an empty queue.
   task automatic test_empty_dequeue();
      spdq_pkg::req_type r;
      r.action     = spdq_pkg::ACT_DEQUEUE;
      r.proc_id    = 16'hFFFF;
      r.prio_level = 4'hF;
      send_request(r);
   endtask

   // Fill the queue with ties and out-of-range priorities, then push one more.
   task automatic test_fill_to_full();
      logic [3:0] prios[16] = '{4'd5, 4'd10, 4'd1, 4'd5, 4'd0, 4'd15, 4'd11, 4'd5,
                                4'd10, 4'd3, 4'd12, 4'd13, 4'd14, 4'd1, 4'd2, 4'd9};
      spdq_pkg::req_type r;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         r.action     = spdq_pkg::ACT_ENQUEUE;
         r.proc_id    = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'(16'h1000 + i * 16'h0111);
         r.prio_level = prios[i % 16];
         send_request(r);
      end
      r.action     = spdq_pkg::ACT_ENQUEUE;
      r.proc_id    = 16'hFFFF;
      r.prio_level = 4'hF;
      send_request(r);
   endtask

   // Take a few entries off the head of a full queue.
   task automatic test_head_dequeue();
      for (int i = 0; i < 4; i++)
         send_request(make_request(spdq_pkg::ACT_DEQUEUE));
   endtask

   // Mixed traffic in phases that lean toward filling, draining or neither.
   task automatic test_random_traffic();
      int enqueue_percent;
      enqueue_percent = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_LENGTH == 0) begin
            case ((n / PHASE_LENGTH) % 3)
               0: begin
                  enqueue_percent = 80;
               end
               1: begin
                  enqueue_percent = 20;
               end
               default: begin
                  enqueue_percent = 50;
               end
            endcase
         end
         if ($urandom_range(0, 99) < enqueue_percent)
            send_request(make_request(spdq_pkg::ACT_ENQUEUE));
         else
            send_request(make_request(spdq_pkg::ACT_DEQUEUE));
      end
   endtask

   // Main sequence.
   initial begin
      repeat (11) @(negedge clock);
      reset = 1'b0;
      test_empty_dequeue();
      test_fill_to_full();
      test_head_dequeue();
      test_random_traffic();
      @(negedge clock);
      start = 1'b0;
      while (expected_rsps.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2000000;
      $display("tb: done, errors");
      $finish;
   end

endmodule
